// ===== hw/rtl/awbg_pkg.sv =====
// shared types and constants for the awb gain block
`default_nettype none
package awbg_pkg;

  localparam int unsigned UnityW     = 12;
  localparam int unsigned RatioW     = 16;
  localparam int unsigned UnityReset = 256;
  localparam int unsigned RatioOne   = 512;

  // divider operand widths
  localparam int unsigned NumW = 28;
  localparam int unsigned DenW = 16;

  typedef struct packed {
    logic [15:0] measured_rg;
    logic [15:0] measured_bg;
    logic [15:0] golden_rg;
    logic [15:0] golden_bg;
  } awbg_in_t;

  typedef struct packed {
    logic [15:0] red_gain;
    logic [15:0] green_gain;
    logic [15:0] blue_gain;
    logic        status;
  } awbg_out_t;

endpackage : awbg_pkg
`default_nettype wire

// ===== hw/rtl/awbg_div.sv =====
// pipelined restoring divider, one quotient bit per stage, with side data
`default_nettype none
module awbg_div import awbg_pkg::*; #(
  parameter int unsigned NW = NumW,
  parameter int unsigned DW = DenW,
  parameter int unsigned SW = 1
) (
  input  wire logic          clk,
  input  wire logic          en,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  input  wire logic [SW-1:0] side_in,
  output logic      [NW-1:0] quo,
  output logic      [SW-1:0] side_out
);

  // one bit per stage, all stages advance together
  for (genvar i = 0; i < NW; i++) begin : g_stage
    logic [NW-1:0] q_in;
    logic [DW:0]   rem_in;
    logic [DW-1:0] d_in;
    logic [SW-1:0] s_in;
    logic [NW-1:0] q_r;
    logic [DW:0]   rem_r;
    logic [DW-1:0] d_r;
    logic [SW-1:0] s_r;
    logic [DW+1:0] sh;
    logic [DW+1:0] df;

    // first stage takes the operands, later ones the previous stage
    if (i == 0) begin : g_first
      assign q_in   = num;
      assign rem_in = '0;
      assign d_in   = den;
      assign s_in   = side_in;
    end else begin : g_next
      assign q_in   = g_stage[i-1].q_r;
      assign rem_in = g_stage[i-1].rem_r;
      assign d_in   = g_stage[i-1].d_r;
      assign s_in   = g_stage[i-1].s_r;
    end

    assign sh = {rem_in, q_in[NW-1]};
    assign df = sh - {2'b00, d_in};
    always_ff @(posedge clk) begin
      if (en) begin
        if (!df[DW+1]) begin
          rem_r <= df[DW:0];
        end else begin
          rem_r <= sh[DW:0];
        end
        q_r <= {q_in[NW-2:0], ~df[DW+1]};
        d_r <= d_in;
        s_r <= s_in;
      end
    end
  end

  assign quo      = g_stage[NW-1].q_r;
  assign side_out = g_stage[NW-1].s_r;

endmodule : awbg_div
`default_nettype wire

// ===== hw/rtl/awb_gain_from_ratio_top.sv =====
// Gain calculator: one word per cycle unless the output stalls. Pipelined
// restoring dividers (one quotient bit per stage) set the depth: the first two
// form the ratios golden*512/measured, the next four the gains. A stall freezes
// the whole pipe. Any zero input or zero ratio yields status 1 and zero gains.
`default_nettype none
module awb_gain_from_ratio_top import awbg_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire awbg_in_t          in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output awbg_out_t              out_data,
  input  wire logic              cfg_we,
  input  wire logic [UnityW-1:0] cfg_data
);

  localparam int unsigned Lat = 2 * NumW + 1;

  logic [UnityW-1:0] unity_r;
  logic              en;
  logic [Lat-1:0]    vld_r;
  awbg_out_t         res_r;
  logic              ov_r;

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unity_r <= UnityW'(UnityReset);
    end else if (cfg_we) begin
      unity_r <= cfg_data;
    end
  end

  // whole pipe moves unless the output is full and stalled
  assign en       = !(ov_r && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[Lat-2:0], in_valid};
    end
  end

  // stage a: ratio dividers
  logic zin, zin_r, zin_b;
  assign zin_r = (in_data.measured_rg == '0) || (in_data.golden_rg == '0);
  assign zin_b = (in_data.measured_bg == '0) || (in_data.golden_bg == '0);
  assign zin   = zin_r || zin_b;

  logic [NumW-1:0] rq, bq;
  logic            z1, z2;
  awbg_div #(.SW(1)) u_rr (
    .clk(clk), .en(en),
    .num({3'b000, in_data.golden_rg, 9'd0}),
    .den(zin ? 16'd1 : in_data.measured_rg),
    .side_in(zin_r), .quo(rq), .side_out(z1)
  );
  awbg_div #(.SW(1)) u_br (
    .clk(clk), .en(en),
    .num({3'b000, in_data.golden_bg, 9'd0}),
    .den(zin ? 16'd1 : in_data.measured_bg),
    .side_in(zin_b), .quo(bq), .side_out(z2)
  );

  // stage b: branch flags, register before gain dividers
  logic [15:0] rr, br;
  assign rr = rq[15:0];
  assign br = bq[15:0];

  logic fail_b;
  assign fail_b = z1 || z2 || (rr == '0) || (br == '0);

  logic rr_hi, br_hi, both_hi;
  assign rr_hi   = rr[15:9] != '0;
  assign br_hi   = br[15:9] != '0;
  assign both_hi = rr_hi && br_hi;

  // numerators and denominators for the four gain dividers
  logic [NumW-1:0] n3_nxt, n4_nxt, n3_r, n4_r;
  logic [15:0]     d1_nxt, d2_nxt, d3_nxt, d4_nxt;
  logic [15:0]     d1_r, d2_r, d3_r, d4_r;
  logic [3:0]      sel_nxt, sel_r; // fail, both_hi, rr_hi, br_hi
  logic [NumW-1:0] urr, ubr, u512;
  assign urr  = NumW'(unity_r) * NumW'(rr);
  assign ubr  = NumW'(unity_r) * NumW'(br);
  assign u512 = {7'd0, unity_r, 9'd0};

  always_comb begin
    if (both_hi) begin
      n3_nxt = urr; n4_nxt = ubr;
      d3_nxt = 16'(RatioOne); d4_nxt = 16'(RatioOne);
    end else begin
      n3_nxt = ubr; n4_nxt = urr;
      d3_nxt = rr; d4_nxt = br;
    end
    d1_nxt = rr;
    d2_nxt = br;
    if (fail_b) begin
      d1_nxt = 16'd1; d2_nxt = 16'd1; d3_nxt = 16'd1; d4_nxt = 16'd1;
    end
    sel_nxt = {fail_b, both_hi, rr_hi, br_hi};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n3_r  <= n3_nxt;
      n4_r  <= n4_nxt;
      d1_r  <= d1_nxt;
      d2_r  <= d2_nxt;
      d3_r  <= d3_nxt;
      d4_r  <= d4_nxt;
      sel_r <= sel_nxt;
    end
  end

  // stage c: gain dividers, branch flags carried alongside
  logic [NumW-1:0] g1, g2, g3, g4;
  logic            fail_o, both_o, rrhi_o, brhi_o;
  awbg_div #(.SW(1)) u_g1 (
    .clk(clk), .en(en), .num(u512), .den(d1_r),
    .side_in(sel_r[3]), .quo(g1), .side_out(fail_o)
  );
  awbg_div #(.SW(1)) u_g2 (
    .clk(clk), .en(en), .num(u512), .den(d2_r),
    .side_in(sel_r[2]), .quo(g2), .side_out(both_o)
  );
  awbg_div #(.SW(1)) u_g3 (
    .clk(clk), .en(en), .num(n3_r), .den(d3_r),
    .side_in(sel_r[1]), .quo(g3), .side_out(rrhi_o)
  );
  awbg_div #(.SW(1)) u_g4 (
    .clk(clk), .en(en), .num(n4_r), .den(d4_r),
    .side_in(sel_r[0]), .quo(g4), .side_out(brhi_o)
  );

  // output assembly and output register
  awbg_out_t res_nxt;
  logic      use_r;
  always_comb begin
    // reference channel: the one whose green gain is larger, red on a tie
    if (rrhi_o) begin
      use_r = 1'b0;
    end else if (brhi_o) begin
      use_r = 1'b1;
    end else begin
      use_r = g1[15:0] >= g2[15:0];
    end
    res_nxt.status = fail_o;
    if (fail_o) begin
      res_nxt.red_gain = '0; res_nxt.green_gain = '0; res_nxt.blue_gain = '0;
    end else if (both_o) begin
      res_nxt.red_gain   = g3[15:0];
      res_nxt.green_gain = {4'd0, unity_r};
      res_nxt.blue_gain  = g4[15:0];
    end else if (use_r) begin
      res_nxt.red_gain   = {4'd0, unity_r};
      res_nxt.green_gain = g1[15:0];
      res_nxt.blue_gain  = g3[15:0];
    end else begin
      res_nxt.red_gain   = g4[15:0];
      res_nxt.green_gain = g2[15:0];
      res_nxt.blue_gain  = {4'd0, unity_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (en) begin
      ov_r <= vld_r[Lat-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = ov_r;
  assign out_data  = res_r;

endmodule : awb_gain_from_ratio_top
`default_nettype wire

// ===== hw/rtl/awbg_checker.sv =====
// port-level checker for the awb gain block, bound to the top level
`default_nettype none
module awbg_checker import awbg_pkg::*; (
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_stall,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire awbg_out_t out_data
);

  // stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled word changed");

  // failed word carries zero gains
  a_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status |->
      out_data.red_gain == '0 && out_data.green_gain == '0 &&
      out_data.blue_gain == '0)
    else $error("failed word has gains");

  // input stall only with a full, stalled output
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("needless input stall");

  // no result right after reset
  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result after reset");

endmodule : awbg_checker

bind awb_gain_from_ratio_top awbg_checker u_awbg_checker (
  .clk(clk), .rst_n(rst_n), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
`default_nettype wire

// ===== tb/awb_gain_from_ratio_top_tb.sv =====
// self-checking testbench for the awb channel gain calculator
`timescale 1ns / 100ps
module awb_gain_from_ratio_top_tb;
  import awbg_pkg::*;

  localparam int Latency = 2 * NumW + 3;
  localparam int NumRandom = 1750;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  awbg_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  awbg_out_t out_data;
  logic cfg_we = 1'b0;
  logic [UnityW-1:0] cfg_data = '0;

  int err_count = 0;
  bit calm = 1'b0;

  awb_gain_from_ratio_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  // print one mismatch line and count it
  function automatic void report(string what, int unsigned got, int unsigned want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    err_count++;
  endfunction

  // gain predictor and store of expected gain words
  class gain_scoreboard;
    awbg_out_t pending_gains[$];
    logic [UnityW-1:0] unity = UnityW'(UnityReset);

    function automatic logic [15:0] q16(logic [31:0] num, logic [31:0] den);
      return 16'(num / den);
    endfunction

    function automatic awbg_out_t predict(awbg_in_t w);
      awbg_out_t res;
      logic [31:0] u, rr, br, gr, gb;
      bit use_r;
      res = '0;
      res.status = 1'b1;
      u = 32'(unity);
      if (w.measured_rg == 0 || w.measured_bg == 0 || w.golden_rg == 0 || w.golden_bg == 0)
        return res;
      rr = 32'(q16(RatioOne * w.golden_rg, 32'(w.measured_rg)));
      br = 32'(q16(RatioOne * w.golden_bg, 32'(w.measured_bg)));
      if (rr == 0 || br == 0) return res;
      res.status = 1'b0;
      if (rr >= RatioOne && br >= RatioOne) begin
        res.red_gain = q16(u * rr, RatioOne);
        res.green_gain = 16'(u);
        res.blue_gain = q16(u * br, RatioOne);
      end else begin
        if (rr >= RatioOne) use_r = 1'b0;
        else if (br >= RatioOne) use_r = 1'b1;
        else begin
          gr = 32'(q16(u * RatioOne, rr));
          gb = 32'(q16(u * RatioOne, br));
          use_r = gr >= gb;
        end
        if (use_r) begin
          res.red_gain = 16'(u);
          res.green_gain = q16(u * RatioOne, rr);
          res.blue_gain = q16(u * br, rr);
        end else begin
          res.red_gain = q16(u * rr, br);
          res.green_gain = q16(u * RatioOne, br);
          res.blue_gain = 16'(u);
        end
      end
      return res;
    endfunction

    function void note_input(awbg_in_t w);
      pending_gains.push_back(predict(w));
    endfunction

    function void check_result(awbg_out_t got);
      awbg_out_t want;
      if (pending_gains.size() == 0) begin
        report("unexpected word", 1, 0);
        return;
      end
      want = pending_gains.pop_front();
      if (got.red_gain !== want.red_gain) report("red_gain", got.red_gain, want.red_gain);
      if (got.green_gain !== want.green_gain)
        report("green_gain", got.green_gain, want.green_gain);
      if (got.blue_gain !== want.blue_gain) report("blue_gain", got.blue_gain, want.blue_gain);
      if (got.status !== want.status) report("status", got.status, want.status);
    endfunction
  endclass

  gain_scoreboard sb = new();

  // sample both channels at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_input(in_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
    end
  end

  // receiver stalls in random bursts
  initial begin
    @(negedge clk);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(negedge clk);
        out_stall <= 1'b0;
      end
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  end

  // send one word and hold it until accepted
  task automatic send_word(awbg_in_t w);
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
  endtask

  task automatic send_fields(int unsigned mrg, int unsigned mbg, int unsigned grg,
                             int unsigned gbg);
    awbg_in_t w;
    w.measured_rg = 16'(mrg);
    w.measured_bg = 16'(mbg);
    w.golden_rg = 16'(grg);
    w.golden_bg = 16'(gbg);
    send_word(w);
  endtask

  // wait until all results are in, then write the unity gain
  task automatic drain_and_set_unity(logic [UnityW-1:0] value);
    in_valid <= 1'b0;
    while (sb.pending_gains.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    sb.unity = value;
    @(negedge clk);
  endtask

  // random ratio set, mostly near realistic values with some wide noise
  function automatic int unsigned pick_ratio();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 65535);
      1: return $urandom_range(0, 4);
      2: return 65535 - $urandom_range(0, 3);
      default: return $urandom_range(200, 900);
    endcase
  endfunction

  task automatic random_phase(int count);
    for (int i = 0; i < count; i++)
      send_fields(pick_ratio(), pick_ratio(), pick_ratio(), pick_ratio());
  endtask

  // stimulus
  initial begin
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // directed: zero inputs, zero ratios, each branch, field extremes
    send_fields(0, 500, 500, 500);
    send_fields(500, 0, 500, 500);
    send_fields(500, 500, 0, 500);
    send_fields(500, 500, 500, 0);
    send_fields(65535, 500, 1, 500);
    send_fields(500, 65535, 500, 1);
    send_fields(400, 400, 600, 700);
    send_fields(400, 600, 600, 400);
    send_fields(600, 400, 400, 600);
    send_fields(600, 700, 400, 400);
    send_fields(700, 600, 400, 400);
    send_fields(500, 500, 500, 500);
    send_fields(1, 1, 65535, 65535);
    send_fields(65535, 65535, 65535, 65535);
    send_fields(1, 1, 1, 1);
    send_fields(128, 128, 65535, 1);
    send_fields(16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555);
    drain_and_set_unity(12'hFFF);
    send_fields(65535, 1, 1, 65535);
    send_fields(1, 65535, 65535, 1);
    send_fields(400, 400, 600, 700);
    random_phase(400);
    drain_and_set_unity(12'd1);
    send_fields(600, 700, 400, 400);
    random_phase(400);
    drain_and_set_unity(12'd0);
    random_phase(100);
    drain_and_set_unity(UnityW'($urandom_range(1, 4095)));
    random_phase(450);
    calm = 1'b1;
    drain_and_set_unity(UnityW'(UnityReset));
    random_phase(400);
    in_valid <= 1'b0;
    while (sb.pending_gains.size() != 0) @(negedge clk);
    repeat (Latency + 10) @(negedge clk);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
